[design/sfd_pkg.sv]
// sfd_pkg: shared constants and types for the sensor frame deframer
// no dependencies; imported by sensor_frame_deframer_core
package sfd_pkg;

	localparam logic [7:0] SYNC_BYTE     = 8'hAA;
	localparam logic [7:0] TIME_TYPE     = 8'h05;
	localparam logic [7:0] TYPE_MIN      = 8'h01;
	localparam logic [7:0] TYPE_MAX      = 8'h05;
	localparam logic [3:0] TYPE_POS      = 4'd2;
	localparam logic [3:0] CHECK_POS_MIN = 4'd3;
	localparam logic [3:0] PAYLOAD_POS   = 4'd4;
	localparam logic [3:0] LONG_LAST     = 4'd10;
	localparam logic [3:0] SHORT_LAST    = 4'd6;
	localparam int         PAYLOAD_DEPTH = 6;
	localparam int         PIDX_W        = $clog2(PAYLOAD_DEPTH);

	// header hunt state
	typedef enum logic [1:0] {
		HUNT     = 2'd0,
		ONE_SYNC = 2'd1,
		IN_FRAME = 2'd2
	} hunt_t;

endpackage

[design/sensor_frame_deframer_core.sv]
// sensor_frame_deframer_core: byte-stream deframer for sensor frames
// depends on sfd_pkg (constants, hunt state type)
//
// usage:
//   input channel: one received serial byte per transfer on rx_byte
//   (in_valid / in_ready). the block hunts for two 0xAA header bytes,
//   then collects type, length, payload and checksum bytes.
//   output channel: one transfer per good frame (checksum matches the
//   8-bit sum of all earlier frame bytes, type 1 to 5) carrying
//   frame_type and up to three big-endian 16-bit values. bad frames
//   are dropped silently and the hunt restarts.
//   output timing: the checksum byte passes the input register, then
//   the frame check loads the result register and raises out_valid.
//   throughput: one byte per cycle unless the receiver stalls; the
//   frame state update is a single short step between the input
//   register and the result register. the input register lets a new
//   byte be taken while a finished result waits in the result register.
//   reset (arst_n low): both registers empty, hunt state cleared,
//   position, sum and type byte zeroed.
//   receiver stall: the result register holds, the input register
//   fills, then in_ready drops until out_ready returns.
module sensor_frame_deframer_core
	import sfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  frame_type,
	output logic [15:0] first_value,
	output logic [15:0] second_value,
	output logic [15:0] third_value
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	hunt_t      hunt_q;
	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] kind_q;
	logic [7:0] store_q [PAYLOAD_DEPTH];

	// result register
	logic        out_valid_q;
	logic [2:0]  type_q;
	logic [15:0] first_q;
	logic [15:0] second_q;
	logic [15:0] third_q;

	logic            advance;
	logic            step;
	logic [3:0]      last;
	logic            frame_end;
	logic            frame_ok;
	logic            emit;
	logic [3:0]      pidx_full;
	logic [PIDX_W-1:0] pidx;

	// the stage moves when the result register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// last frame position (the checksum byte) follows from the type byte
	assign last      = (kind_q == TIME_TYPE) ? LONG_LAST : SHORT_LAST;
	assign frame_end = (hunt_q == IN_FRAME) && (pos_q >= CHECK_POS_MIN)
		&& (pos_q >= last);
	assign frame_ok  = (byte_s1 == sum_q) && (kind_q >= TYPE_MIN)
		&& (kind_q <= TYPE_MAX);
	assign emit      = frame_end && frame_ok;
	assign pidx_full = pos_q - PAYLOAD_POS;
	assign pidx      = pidx_full[PIDX_W-1:0];

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame state update, one byte per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_q <= HUNT;
			pos_q  <= '0;
			sum_q  <= '0;
			kind_q <= '0;
		end else if (step) begin
			case (hunt_q)
				ONE_SYNC: begin
					if (byte_s1 == SYNC_BYTE) begin
						hunt_q <= IN_FRAME;
						pos_q  <= TYPE_POS;
						sum_q  <= SYNC_BYTE + SYNC_BYTE;
					end else begin
						hunt_q <= HUNT;
					end
				end
				IN_FRAME: begin
					if (pos_q == TYPE_POS) begin
						kind_q <= byte_s1;
					end
					if (frame_end) begin
						hunt_q <= HUNT;
						pos_q  <= '0;
					end else begin
						sum_q <= sum_q + byte_s1;
						pos_q <= pos_q + 4'd1;
					end
				end
				default: begin
					hunt_q <= (byte_s1 == SYNC_BYTE) ? ONE_SYNC : HUNT;
				end
			endcase
		end
	end

	// payload bytes 4..9, no reset needed: a result only reads bytes of its own frame
	always_ff @(posedge clk) begin
		if (step && hunt_q == IN_FRAME && pos_q >= PAYLOAD_POS && pos_q < last) begin
			store_q[pidx] <= byte_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			type_q  <= kind_q[2:0];
			first_q <= {store_q[0], store_q[1]};
			if (kind_q == TIME_TYPE) begin
				second_q <= {store_q[2], store_q[3]};
				third_q  <= {store_q[4], store_q[5]};
			end else begin
				second_q <= '0;
				third_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_type   = type_q;
	assign first_value  = first_q;
	assign second_value = second_q;
	assign third_value  = third_q;

	// checks
	a_type_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (type_q >= 3'd1 && type_q <= 3'd5))
		else $error("result type out of range");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && type_q != TIME_TYPE[2:0]) |-> (second_q == '0 && third_q == '0))
		else $error("short frame result has nonzero extra values");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LONG_LAST)
		else $error("frame position past longest frame");

	a_hunt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(hunt_q != IN_FRAME) |-> (pos_q == '0))
		else $error("position not cleared outside a frame");

	a_emit_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |=> (hunt_q == HUNT && out_valid_q))
		else $error("good frame did not load result and restart hunt");

endmodule
